// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the receiver RTL.
// Every check is clocked on the rising edge and held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define GFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication check.
`define GFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define GFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gfr_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the GMII receiver.
// No dependencies.
`default_nettype none

package gfr_pkg;

    localparam int DELAY_DEPTH       = 5;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [7:0]  SFD_BYTE      = 8'hD5;
    localparam logic [15:0] HDR_BYTES     = 16'd14;
    localparam logic [15:0] LEN_HI_IDX    = 16'd13;
    localparam logic [15:0] LEN_LO_IDX    = 16'd12;
    localparam logic [15:0] MIN_FRAME     = 16'd64;
    localparam logic [15:0] MAX_FRAME     = 16'd1500;
    localparam logic [15:0] MAX_LENGTH    = 16'h05DC;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] LEN_TYPE_INIT = 16'hFFFF;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_RESIDUE   = 32'hDEBB_20E3;

    typedef enum logic {
        CMD_BYTE,
        CMD_END
    } t_cmd_kind;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       now_valid;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_error;
        logic        out_last;
        logic        status_valid;
        logic [15:0] frame_bytes;
        logic        frame_good;
        logic        undersize;
        logic        oversize;
        logic        length_error;
        logic        crc_error;
    } t_result;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gfr_if.sv =====
// Valid/ready stream interfaces for the GMII receiver: GMII side and frame side.
// No dependencies.
`default_nettype none

interface gfr_rx_if;
    logic       valid;
    logic       ready;
    logic       rx_valid;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_valid, input rx_byte, output ready);
endinterface

interface gfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_error;
    logic        out_last;
    logic        status_valid;
    logic [15:0] frame_bytes;
    logic        frame_good;
    logic        undersize;
    logic        oversize;
    logic        length_error;
    logic        crc_error;

    modport source (
        output valid, output out_byte, output out_error, output out_last,
        output status_valid, output frame_bytes, output frame_good,
        output undersize, output oversize, output length_error,
        output crc_error, input ready
    );
    modport sink (
        input valid, input out_byte, input out_error, input out_last,
        input status_valid, input frame_bytes, input frame_good,
        input undersize, input oversize, input length_error,
        input crc_error, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/gmii_ethernet_frame_receiver_top.sv =====
// Top level of the GMII frame receiver: front end, command queue, back end.
// Depends on gfr_pkg, gfr_if, gfr_front, gfr_queue, gfr_back.
//
//   channel  dir  handshake                 payload
//   i_rx     in   i_rx.valid / i_rx.ready   rx_valid, rx_byte (one GMII cycle)
//   o_out    out  o_out.valid / o_out.ready frame byte, last, error, status
//
// One GMII beat is accepted per cycle while the queue has room. A frame byte
// passes the five-beat delay line, the command queue and the output register.
// The back end sets throughput: one command a cycle unless the output stalls.
// Synchronous active-low reset clears the delay line, phase, queue and frame
// state. A stalled output fills the queue; i_rx.ready drops when it is full.
`default_nettype none

module gmii_ethernet_frame_receiver_top #(
    parameter int QUEUE_DEPTH = gfr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    gfr_rx_if.sink     i_rx,
    gfr_out_if.source  o_out
);
    import gfr_pkg::*;

    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    gfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    gfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    gfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/gfr_front.sv =====
// Front end: GMII delay line and delimiter/frame phase tracking.
// Emits byte and end-of-frame commands. Depends on gfr_pkg, gfr_rx_if.
`default_nettype none

module gfr_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    gfr_rx_if.sink            i_rx,
    input  wire               i_q_full,
    output logic              o_push,
    output gfr_pkg::t_cmd     o_cmd
);
    import gfr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FIRST,
        PH_DATA,
        PH_DRAIN
    } t_phase;

    typedef struct packed {
        logic       v;
        logic [7:0] b;
    } t_tap;

    t_tap   r_line [DELAY_DEPTH];
    t_phase r_phase;
    t_phase n_phase;
    t_tap   cur;
    logic   accept;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;
    assign cur        = r_line[DELAY_DEPTH-1];

    always_comb begin
        n_phase         = r_phase;
        o_push          = 1'b0;
        o_cmd.kind      = CMD_BYTE;
        o_cmd.data      = cur.b;
        o_cmd.now_valid = i_rx.rx_valid;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (cur.v && cur.b == SFD_BYTE) begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    // byte right after the delimiter goes in without a valid check
                    o_push  = 1'b1;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    o_push = 1'b1;
                    if (!cur.v) begin
                        o_cmd.kind = CMD_END;
                        n_phase    = PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            for (int i = 0; i < DELAY_DEPTH; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                r_line[0] <= '{v: i_rx.rx_valid, b: i_rx.rx_byte};
                for (int i = 1; i < DELAY_DEPTH; i++) begin
                    r_line[i] <= r_line[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gfr_queue.sv =====
// Small command FIFO between the front and back ends.
// Depends on gfr_pkg and assert_macros.svh.
`default_nettype none

module gfr_queue #(
    parameter int DEPTH = gfr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  gfr_pkg::t_cmd     i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output gfr_pkg::t_cmd     o_cmd,
    input  wire               i_pop
);
    import gfr_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `GFR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count above depth")
    `GFR_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")

endmodule

`default_nettype wire

// ===== rtl/gfr_back.sv =====
// Back end: frame counters, length/type capture, CRC-32 and status, with
// the output register. Depends on gfr_pkg, gfr_out_if, assert_macros.svh.
`default_nettype none

module gfr_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cmd_valid,
    input  gfr_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    gfr_out_if.source         o_out
);
    import gfr_pkg::*;
    `include "assert_macros.svh"

    logic [15:0] r_byte_count,   n_byte_count;
    logic [15:0] r_payload_count, n_payload_count;
    logic [15:0] r_length_type,  n_length_type;
    logic        r_fwd_on,       n_fwd_on;
    logic [31:0] r_crc,          n_crc;
    logic [7:0]  r_held,         n_held;
    logic        r_res_valid;
    t_result     r_res;
    t_result     res;
    logic        emit;
    logic        take;
    logic        fcs_err, under, over, len_err, good;

    assign take  = i_cmd_valid && (!r_res_valid || o_out.ready);
    assign o_pop = take;

    assign fcs_err = (r_crc != CRC_RESIDUE);
    assign under   = (r_byte_count < MIN_FRAME);
    assign over    = (r_byte_count > MAX_FRAME);
    assign len_err = (r_length_type <= MAX_LENGTH) && (r_length_type != r_payload_count);
    assign good    = !(fcs_err || under || over || len_err);

    always_comb begin
        n_byte_count    = r_byte_count;
        n_payload_count = r_payload_count;
        n_length_type   = r_length_type;
        n_fwd_on        = r_fwd_on;
        n_crc           = r_crc;
        n_held          = r_held;
        emit            = 1'b0;
        res             = '0;
        res.out_byte    = i_cmd.data;
        case (i_cmd.kind)
            CMD_BYTE: begin
                if (r_byte_count < HDR_BYTES) begin
                    emit = 1'b1;
                    if (r_byte_count == LEN_LO_IDX) begin
                        n_length_type = {r_length_type[15:8], i_cmd.data};
                    end else if (r_byte_count == LEN_HI_IDX) begin
                        n_length_type = {r_length_type[7:0], i_cmd.data};
                    end
                end else if (r_fwd_on) begin
                    n_payload_count = r_payload_count + 1'b1;
                    if (i_cmd.now_valid && r_length_type != '0 &&
                        r_payload_count < r_length_type - 1'b1) begin
                        emit = 1'b1;
                    end else begin
                        // first byte not forwarded is kept for the last beat
                        n_held   = i_cmd.data;
                        n_fwd_on = 1'b0;
                    end
                end
                if (r_byte_count != COUNT_MAX) begin
                    n_byte_count = r_byte_count + 1'b1;
                end
                n_crc = crc32_byte(r_crc, i_cmd.data);
            end
            CMD_END: begin
                emit             = 1'b1;
                res.out_byte     = r_held;
                res.out_error    = !good;
                res.out_last     = 1'b1;
                res.status_valid = 1'b1;
                res.frame_bytes  = r_byte_count;
                res.frame_good   = good;
                res.undersize    = under;
                res.oversize     = over;
                res.length_error = len_err;
                res.crc_error    = fcs_err;
                n_byte_count     = '0;
                n_payload_count  = '0;
                n_length_type    = LEN_TYPE_INIT;
                n_fwd_on         = 1'b1;
                n_crc            = CRC_INIT;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_payload_count <= '0;
            r_length_type   <= LEN_TYPE_INIT;
            r_fwd_on        <= 1'b1;
            r_crc           <= CRC_INIT;
            r_held          <= '0;
            r_res_valid     <= 1'b0;
        end else begin
            if (take) begin
                r_byte_count    <= n_byte_count;
                r_payload_count <= n_payload_count;
                r_length_type   <= n_length_type;
                r_fwd_on        <= n_fwd_on;
                r_crc           <= n_crc;
                r_held          <= n_held;
            end
            if (take && emit) begin
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_res <= res;
        end
    end

    assign o_out.valid        = r_res_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.out_error    = r_res.out_error;
    assign o_out.out_last     = r_res.out_last;
    assign o_out.status_valid = r_res.status_valid;
    assign o_out.frame_bytes  = r_res.frame_bytes;
    assign o_out.frame_good   = r_res.frame_good;
    assign o_out.undersize    = r_res.undersize;
    assign o_out.oversize     = r_res.oversize;
    assign o_out.length_error = r_res.length_error;
    assign o_out.crc_error    = r_res.crc_error;

    `GFR_ASSERT_NEXT(a_end_restart, i_clk, i_rst_n, take && i_cmd.kind == CMD_END,
        r_byte_count == '0 && r_crc == CRC_INIT && r_fwd_on, "frame state not restarted")
    `GFR_ASSERT_IMP(a_last_status, i_clk, i_rst_n, r_res_valid,
        r_res.out_last == r_res.status_valid, "last beat and status disagree")

endmodule

`default_nettype wire

// ===== tb/gmii_ethernet_frame_receiver_top_tb.sv =====
// Self-checking bench for gmii_ethernet_frame_receiver_top: GMII beats in, frame beats out.
// Uses gfr_pkg (t_result) and the stream interfaces from gfr_if.
// Beats are predicted by a local model of the delay line, frame phases and CRC, or pinned in DIR_TABLE.
`timescale 1ns / 100ps

module gmii_ethernet_frame_receiver_top_tb;
    import gfr_pkg::t_result;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          RANDOM_BEATS   = 60;
    localparam logic [7:0]  DELIM          = 8'hD5;
    localparam logic [7:0]  PREAMBLE       = 8'h55;
    localparam logic [15:0] HEADER_LEN     = 16'd14;
    localparam logic [15:0] LEN_LO_POS     = 16'd12;
    localparam logic [15:0] LEN_HI_POS     = 16'd13;
    localparam logic [15:0] RUNT_LIMIT     = 16'd64;
    localparam logic [15:0] GIANT_LIMIT    = 16'd1500;
    localparam logic [15:0] LEN_FIELD_MAX  = 16'h05DC;
    localparam logic [15:0] COUNT_SAT      = 16'hFFFF;
    localparam logic [15:0] LEN_NONE       = 16'hFFFF;
    localparam logic [15:0] ETH_TYPE_IP    = 16'h0800;
    localparam logic [31:0] CRC_SEED       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_REFL_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_GOOD_RES   = 32'hDEBB_20E3;

    typedef enum logic [1:0] {SEEK_SFD, AFTER_SFD, IN_FRAME, FRAME_DRAIN} rx_phase_t;
    typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;
    typedef enum logic [1:0] {PIN_OFF, PIN_NONE, PIN_FWD, PIN_END} pin_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        pin_t        pin;
        logic [15:0] arg;   // forwarded byte, or frame_bytes on the end beat
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    // Two runts from reset: the first ends on an invalid beat, the second starts
    // on a delimiter whose next byte is invalid yet still taken as a frame byte.
    // Neither holds back a payload byte, so the end beat carries zero.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        {1'b0, 8'h00, PIN_NONE, 16'h0000},
        {1'b0, 8'hD5, PIN_NONE, 16'h0000},
        {1'b1, 8'hFF, PIN_NONE, 16'h0000},
        {1'b1, 8'h00, PIN_NONE, 16'h0000},
        {1'b0, 8'hFF, PIN_NONE, 16'h0000},
        {1'b1, 8'hD5, PIN_NONE, 16'h0000},
        {1'b1, 8'hFF, PIN_OFF,  16'h0000},
        {1'b1, 8'h00, PIN_OFF,  16'h0000},
        {1'b0, 8'hA5, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_NONE, 16'h0000},
        {1'b0, 8'h00, PIN_FWD,  16'h00FF},
        {1'b0, 8'h00, PIN_FWD,  16'h0000},
        {1'b0, 8'h00, PIN_END,  16'd2},
        {1'b1, 8'hD5, PIN_NONE, 16'h0000},
        {1'b0, 8'h3C, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_OFF,  16'h0000},
        {1'b0, 8'h00, PIN_NONE, 16'h0000},
        {1'b0, 8'h00, PIN_FWD,  16'h003C},
        {1'b0, 8'h00, PIN_END,  16'd1},
        {1'b0, 8'h00, PIN_OFF,  16'h0000}
    };

    logic i_clk;
    logic i_rst_n;

    gfr_rx_if  rx_bus ();
    gfr_out_if out_bus ();

    gmii_ethernet_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_out   (out_bus)
    );

    // receiver model state
    logic [8:0]  gmii_pipe [5];
    rx_phase_t   rx_phase;
    logic [15:0] frame_count;
    logic [15:0] payload_seen;
    logic [15:0] eth_len_field;
    logic        fwd_on;
    logic [31:0] frame_crc;
    logic [7:0]  held_byte;

    t_result frame_beats_due [$];
    int      fail_count;
    int      beats_sent;
    flow_t   flow;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
            r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_REFL_POLY : 32'h0);
        return r;
    endfunction

    function automatic void restart_frame();
        frame_count   = '0;
        payload_seen  = '0;
        eth_len_field = LEN_NONE;
        fwd_on        = 1'b1;
        frame_crc     = CRC_SEED;
    endfunction

    function automatic bit take_frame_byte(input logic [7:0] d, input logic now_v,
                                           inout t_result r);
        bit hit;
        hit = 1'b0;
        if (frame_count < HEADER_LEN) begin
            r.out_byte = d;
            hit = 1'b1;
            if (frame_count == LEN_LO_POS)
                eth_len_field = {eth_len_field[15:8], d};
            else if (frame_count == LEN_HI_POS)
                eth_len_field = {eth_len_field[7:0], d};
        end else if (fwd_on) begin
            // the first payload byte not forwarded becomes the last beat
            if (now_v && eth_len_field != 16'h0 && payload_seen < eth_len_field - 16'd1) begin
                r.out_byte = d;
                hit = 1'b1;
            end else begin
                held_byte = d;
                fwd_on    = 1'b0;
            end
            payload_seen++;
        end
        if (frame_count != COUNT_SAT)
            frame_count++;
        frame_crc = crc_next(frame_crc, d);
        return hit;
    endfunction

    function automatic bit predict_gmii_beat(input logic v, input logic [7:0] d,
                                             output t_result r);
        logic [8:0] oldest;
        bit         hit;
        oldest = gmii_pipe[4];
        for (int i = 4; i > 0; i--)
            gmii_pipe[i] = gmii_pipe[i-1];
        gmii_pipe[0] = {v, d};
        r   = '0;
        hit = 1'b0;
        case (rx_phase)
            SEEK_SFD: begin
                if (oldest[8] && oldest[7:0] == DELIM)
                    rx_phase = AFTER_SFD;
            end
            AFTER_SFD: begin
                rx_phase = IN_FRAME;
                hit = take_frame_byte(oldest[7:0], v, r);
            end
            IN_FRAME: begin
                if (oldest[8]) begin
                    hit = take_frame_byte(oldest[7:0], v, r);
                end else begin
                    r.out_byte     = held_byte;
                    r.out_last     = 1'b1;
                    r.status_valid = 1'b1;
                    r.frame_bytes  = frame_count;
                    r.undersize    = frame_count < RUNT_LIMIT;
                    r.oversize     = frame_count > GIANT_LIMIT;
                    r.length_error = (eth_len_field <= LEN_FIELD_MAX) &&
                                     (eth_len_field != payload_seen);
                    r.crc_error    = frame_crc != CRC_GOOD_RES;
                    r.frame_good   = !(r.undersize | r.oversize | r.length_error | r.crc_error);
                    r.out_error    = !r.frame_good;
                    hit      = 1'b1;
                    rx_phase = FRAME_DRAIN;
                end
            end
            default: begin
                restart_frame();
                rx_phase = SEEK_SFD;
            end
        endcase
        return hit;
    endfunction

    task automatic send_beat(input logic v, input logic [7:0] d, input pin_t pin,
                             input logic [15:0] arg);
        t_result r;
        bit      hit;
        @(negedge i_clk);
        while ((flow == FLOW_SRC_IDLE && $urandom_range(0, 99) < 56) ||
               (flow == FLOW_BOTH && $urandom_range(0, 99) < 8)) begin
            rx_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_bus.valid    <= 1'b1;
        rx_bus.rx_valid <= v;
        rx_bus.rx_byte  <= d;
        @(posedge i_clk);
        while (!rx_bus.ready)
            @(posedge i_clk);
        hit = predict_gmii_beat(v, d, r);
        case (pin)
            PIN_NONE: hit = 1'b0;
            PIN_FWD: begin
                hit = 1'b1;
                r = '0;
                r.out_byte = arg[7:0];
            end
            PIN_END: begin
                // runt after reset: nothing held, bad CRC, under 64 bytes
                hit = 1'b1;
                r = '0;
                r.out_error    = 1'b1;
                r.out_last     = 1'b1;
                r.status_valid = 1'b1;
                r.frame_bytes  = arg;
                r.undersize    = 1'b1;
                r.crc_error    = 1'b1;
            end
            default: ;
        endcase
        if (hit)
            frame_beats_due.push_back(r);
        beats_sent++;
        flow = flow_t'((beats_sent / 64) % 4);
    endtask

    // keep < 0 sends the whole frame, otherwise only the first keep bytes after the SFD
    task automatic send_frame(input int pre, input logic [15:0] len_field, input int pay,
                              input bit bad_fcs, input int keep, input int gap);
        logic [7:0]  body [$];
        logic [31:0] crc_acc;
        int          n_send;
        body = {};
        repeat (12) body.push_back(8'($urandom_range(0, 255)));
        body.push_back(len_field[15:8]);
        body.push_back(len_field[7:0]);
        repeat (pay) body.push_back(8'($urandom_range(0, 255)));
        crc_acc = CRC_SEED;
        foreach (body[i])
            crc_acc = crc_next(crc_acc, body[i]);
        crc_acc = ~crc_acc;
        if (bad_fcs)
            crc_acc[$urandom_range(0, 31)] ^= 1'b1;
        for (int k = 0; k < 4; k++)
            body.push_back(crc_acc[8*k +: 8]);
        n_send = (keep < 0 || keep > body.size()) ? body.size() : keep;
        repeat (pre) send_beat(1'b1, PREAMBLE, PIN_OFF, '0);
        send_beat(1'b1, DELIM, PIN_OFF, '0);
        for (int i = 0; i < n_send; i++)
            send_beat(1'b1, body[i], PIN_OFF, '0);
        repeat (gap) send_beat(1'b0, 8'($urandom_range(0, 255)), PIN_OFF, '0);
    endtask

    always @(negedge i_clk) begin
        case (flow)
            FLOW_SNK_STALL: out_bus.ready <= ($urandom_range(0, 99) >= 56);
            FLOW_BOTH:      out_bus.ready <= ($urandom_range(0, 99) >= 8);
            default:        out_bus.ready <= 1'b1;
        endcase
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (frame_beats_due.size() == 0) begin
                $error("output beat %0h with nothing expected", out_bus.out_byte);
                fail_count++;
            end else begin
                want = frame_beats_due.pop_front();
                check_field("out_byte",     16'(want.out_byte),     16'(out_bus.out_byte));
                check_field("out_error",    16'(want.out_error),    16'(out_bus.out_error));
                check_field("out_last",     16'(want.out_last),     16'(out_bus.out_last));
                check_field("status_valid", 16'(want.status_valid),
                            16'(out_bus.status_valid));
                check_field("frame_bytes",  want.frame_bytes,       out_bus.frame_bytes);
                check_field("frame_good",   16'(want.frame_good),   16'(out_bus.frame_good));
                check_field("undersize",    16'(want.undersize),    16'(out_bus.undersize));
                check_field("oversize",     16'(want.oversize),     16'(out_bus.oversize));
                check_field("length_error", 16'(want.length_error),
                            16'(out_bus.length_error));
                check_field("crc_error",    16'(want.crc_error),    16'(out_bus.crc_error));
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_bus.valid && rx_bus.ready) || (out_bus.valid && out_bus.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int pay;
        int sel;
        int rand_start;
        logic [15:0] lf;
        i_rst_n         = 1'b0;
        rx_bus.valid    = 1'b0;
        rx_bus.rx_valid = 1'b0;
        rx_bus.rx_byte  = '0;
        out_bus.ready   = 1'b0;
        fail_count      = 0;
        beats_sent      = 0;
        flow            = FLOW_FREE;
        for (int i = 0; i < 5; i++)
            gmii_pipe[i] = '0;
        rx_phase  = SEEK_SFD;
        held_byte = '0;
        restart_frame();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TABLE[i])
            send_beat(DIR_TABLE[i].valid, DIR_TABLE[i].data, DIR_TABLE[i].pin,
                      DIR_TABLE[i].arg);

        send_frame(1, 16'h0000, 6, 1'b0, -1, 2);         // zero length field
        send_frame(1, 16'd10, 46, 1'b0, -1, 2);          // padding stripped, 64 bytes
        send_frame(0, 16'd30, 8, 1'b0, -1, 2);           // length mismatch
        send_frame(0, 16'h05DD, 4, 1'b0, -1, 2);         // just above length range
        send_frame(0, ETH_TYPE_IP, 45, 1'b0, -1, 2);     // 63 bytes
        send_frame(0, ETH_TYPE_IP, 46, 1'b1, -1, 2);     // 64 bytes, bad FCS

        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS) begin
            sel = $urandom_range(0, 9);
            pay = $urandom_range(0, 60);
            case ($urandom_range(0, 19))
                0, 1, 2:             lf = 16'h0000;
                3, 4, 5, 6, 7, 8, 9: lf = 16'($urandom_range(16'h05DD, 16'hFFFF));
                10, 11, 12, 13:      lf = 16'(pay);
                default:             lf = 16'($urandom_range(0, LEN_FIELD_MAX));
            endcase
            if (sel < 7) begin
                send_frame($urandom_range(0, 7), lf, pay, $urandom_range(0, 7) == 0, -1,
                           $urandom_range(1, 6));
            end else if (sel < 9) begin
                // truncated frame, sometimes running straight into the next one
                send_frame($urandom_range(0, 7), lf, pay, 1'b0,
                           $urandom_range(0, pay + 17), $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_beat(1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) == 0) ? DELIM :
                                                            8'($urandom_range(0, 255)),
                              PIN_OFF, '0);
            end
        end
        // flush the delay line so the last frame closes
        repeat (12) send_beat(1'b0, 8'h00, PIN_OFF, '0);

        @(negedge i_clk);
        rx_bus.valid <= 1'b0;
        while (frame_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gfr_pkg.sv
rtl/gfr_if.sv
rtl/gfr_front.sv
rtl/gfr_queue.sv
rtl/gfr_back.sv
rtl/gmii_ethernet_frame_receiver_top.sv
tb/gmii_ethernet_frame_receiver_top_tb.sv
